// ----- rtl/core/mma_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_pkg: shared types and constants of the multichannel moving average
// Transaction payload structs and the fixed scaling constants.
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned CH_FIELD_W = 2;
  localparam int unsigned EN_W       = 4;
  localparam int unsigned PROD_W     = 24;
  localparam int unsigned RECIP_W    = 25;
  localparam int unsigned RECIP_FW   = PROD_W + RECIP_W;
  localparam int unsigned RECIP_SH   = 36;

  localparam logic [EN_W-1:0]     EN_RESET      = 4'hF;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE_MV = 12'd3300;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE_CD = 12'd4095;
  // ceil(2^36 / 4095): exact floor division by 4095 for products below 2^24
  localparam logic [RECIP_W-1:0]  RECIP_M       = 25'd16781314;

  typedef struct packed {
    logic [CH_FIELD_W-1:0] channel;
    logic [SAMPLE_W-1:0]   sample;
  } in_t;

  typedef struct packed {
    logic [CH_FIELD_W-1:0] out_channel;
    logic [SAMPLE_W-1:0]   average;
    logic [SAMPLE_W-1:0]   millivolts;
  } out_t;

endpackage

// ----- rtl/core/multichannel_moving_average.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_moving_average: per-channel running-sum moving average
// Takes one sample per cycle unless stalled; returns channel, average, millivolts.
// ----------------------------------------------------------------------------
// A sample transaction is taken every cycle while stall_o is low; its result
// passes history read, total update, scale multiply and reciprocal divide;
// stages hold independently so bubbles collapse under output stall. Sample
// history lives in one single-port read-first RAM of CHANNELS * 2^AVG_BITS
// words: the evicted sample is read and the new one written in the same
// cycle, so successive samples of one channel need no interlock. Running
// totals and ring pointers are flip-flops. After reset the RAM is cleared
// one word a cycle, all CHANNELS * 2^AVG_BITS words, with stall_o held high;
// channel_enable writes are taken throughout. Samples of disabled channels,
// or of channels at or above CHANNELS, are consumed without a result.
module multichannel_moving_average #(
  parameter int unsigned AVG_BITS = 4,
  parameter int unsigned CHANNELS = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  mma_pkg::in_t                data_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output mma_pkg::out_t               data_o,
  input  logic                        cfg_we_i,
  input  logic [mma_pkg::EN_W-1:0]    cfg_data_i
);

  import mma_pkg::*;

  localparam int unsigned WINDOW   = 1 << AVG_BITS;
  localparam int unsigned DEPTH    = CHANNELS * WINDOW;
  localparam int unsigned CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned POS_W    = (AVG_BITS > 0) ? AVG_BITS : 1;
  localparam int unsigned TOT_W    = SAMPLE_W + AVG_BITS;
  localparam int unsigned ADDR_W   = CH_IDX_W + AVG_BITS;
  localparam logic [POS_W-1:0]  POS_MASK = POS_W'(WINDOW - 1);
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);

  // configuration
  logic [EN_W-1:0] en_q;

  // clearing pass
  logic              clr_q, clr_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;

  // per-channel state
  logic [POS_W-1:0] pos_q [CHANNELS];
  logic [TOT_W-1:0] tot_q [CHANNELS];

  // history RAM
  logic [SAMPLE_W-1:0] hist_mem [DEPTH];
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_addr;
  logic [SAMPLE_W-1:0] mem_wdata;
  logic [SAMPLE_W-1:0] rd_q;

  // accept stage
  logic                accept, go, ch_ok;
  logic [CH_IDX_W-1:0] ch_idx;
  logic [POS_W-1:0]    pos_cur, pos_d;
  logic [ADDR_W-1:0]   acc_addr;

  // pipeline
  logic                s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic                en1, en2, en3, en_out;
  logic [CH_IDX_W-1:0] s1_ch_q;
  logic [SAMPLE_W-1:0] s1_smp_q;
  logic [TOT_W-1:0]    tot_new;
  logic [CH_FIELD_W-1:0] s2_ch_q, s3_ch_q;
  logic [SAMPLE_W-1:0] s2_avg_q, s3_avg_q;
  logic [PROD_W-1:0]   s3_prod_q;
  logic [RECIP_FW-1:0] recip_full;
  out_t                out_q;

  // handshake
  assign en_out  = !out_v_q || !stall_i;
  assign en3     = !s3_v_q || en_out;
  assign en2     = !s2_v_q || en3;
  assign en1     = !s1_v_q || en2;
  assign stall_o = clr_q || !en1;
  assign accept  = valid_i && !stall_o;

  assign ch_ok    = 32'(data_i.channel) < CHANNELS;
  assign ch_idx   = CH_IDX_W'(data_i.channel);
  assign go       = accept && en_q[data_i.channel] && ch_ok;
  assign pos_cur  = pos_q[ch_idx] & POS_MASK;
  assign pos_d    = (pos_cur + POS_W'(1)) & POS_MASK;
  assign acc_addr = (ADDR_W'(ch_idx) << AVG_BITS) | ADDR_W'(pos_cur);

  assign mem_we    = clr_q || go;
  assign mem_addr  = clr_q ? clr_cnt_q : acc_addr;
  assign mem_wdata = clr_q ? '0 : data_i.sample;

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + ADDR_W'(1);
      if (clr_cnt_q == CLR_LAST) begin
        clr_d = 1'b0;
      end
    end
  end

  // read-first: the evicted word comes out while the new sample goes in
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[mem_addr] <= mem_wdata;
    end
    if (go) begin
      rd_q <= hist_mem[mem_addr];
    end
  end

  assign tot_new = tot_q[s1_ch_q] - TOT_W'(rd_q) + TOT_W'(s1_smp_q);

  assign recip_full = RECIP_FW'(s3_prod_q) * RECIP_FW'(RECIP_M);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q      <= EN_RESET;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      s3_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        pos_q[i] <= '0;
        tot_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        en_q <= cfg_data_i;
      end
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
      if (go) begin
        pos_q[ch_idx] <= pos_d;
      end
      if (s1_v_q && en2) begin
        tot_q[s1_ch_q] <= tot_new;
      end
      if (en1) begin
        s1_v_q <= go;
      end
      if (en2) begin
        s2_v_q <= s1_v_q;
      end
      if (en3) begin
        s3_v_q <= s2_v_q;
      end
      if (en_out) begin
        out_v_q <= s3_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      s1_ch_q  <= ch_idx;
      s1_smp_q <= data_i.sample;
    end
    if (en2 && s1_v_q) begin
      s2_ch_q  <= CH_FIELD_W'(s1_ch_q);
      s2_avg_q <= SAMPLE_W'(tot_new >> AVG_BITS);
    end
    if (en3 && s2_v_q) begin
      s3_ch_q   <= s2_ch_q;
      s3_avg_q  <= s2_avg_q;
      s3_prod_q <= PROD_W'(s2_avg_q) * PROD_W'(FULL_SCALE_MV);
    end
    if (en_out && s3_v_q) begin
      out_q.out_channel <= s3_ch_q;
      out_q.average     <= s3_avg_q;
      out_q.millivolts  <= SAMPLE_W'(recip_full >> RECIP_SH);
    end
  end

  assign valid_o = out_v_q;
  assign data_o  = out_q;

endmodule

// ----- rtl/core/mma_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_checker: port-level checks on the multichannel moving average
// Watches the top-level ports only; bound to every instance.
// ----------------------------------------------------------------------------
module mma_checker #(
  parameter int unsigned CHANNELS = 4
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     valid_i,
  input logic                     stall_o,
  input mma_pkg::in_t             data_i,
  input logic                     valid_o,
  input logic                     stall_i,
  input mma_pkg::out_t            data_o
);

  import mma_pkg::*;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && stall_o |=> valid_i && $stable(data_i))
    else $error("stalled sample transaction changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(data_o))
    else $error("stalled result transaction changed");

  a_mv_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (32'(data_o.millivolts) * 32'(FULL_SCALE_CD)
                   <= 32'(data_o.average) * 32'(FULL_SCALE_MV)) &&
                ((32'(data_o.millivolts) + 32'd1) * 32'(FULL_SCALE_CD)
                   > 32'(data_o.average) * 32'(FULL_SCALE_MV)))
    else $error("millivolts not the floor of the scaled average");

  a_out_ch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> 32'(data_o.out_channel) < CHANNELS)
    else $error("result for a channel that does not exist");

  a_clear_stall: assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> stall_o)
    else $error("input taken before history clear");

endmodule

bind multichannel_moving_average mma_checker #(
  .CHANNELS (CHANNELS)
) u_mma_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .valid_i    (valid_i),
  .stall_o    (stall_o),
  .data_i     (data_i),
  .valid_o    (valid_o),
  .stall_i    (stall_i),
  .data_o     (data_o)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the multichannel moving average
// Drives sample transactions through a queue-fed driver and predicts the
// per-channel ring, running total and millivolt scaling in the bench. The
// monitor checks every result against the oldest prediction. Runs several
// channel enable masks and idling/stall phases.
// ----------------------------------------------------------------------------
module tb_top;
  import mma_pkg::*;

  localparam int unsigned AVG_BITS     = 4;
  localparam int unsigned CHANNELS     = 4;
  localparam int unsigned WINDOW       = 1 << AVG_BITS;
  localparam int unsigned SUM_W        = SAMPLE_W + AVG_BITS;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PER_PHASE    = 120;

  localparam logic [EN_W-1:0] PHASE_MASK [PHASES] =
    '{4'hF, 4'h5, 4'hA, 4'h0, 4'h1, 4'h8, 4'hE, 4'hF};
  localparam int unsigned SEND_IDLE [4]  = '{0, 57, 0, 17};
  localparam int unsigned RECV_STALL [4] = '{0, 0, 57, 17};

  logic            clk_i      = 1'b0;
  logic            rst_ni     = 1'b0;
  logic            valid_i    = 1'b0;
  logic            stall_o;
  in_t             data_i     = '0;
  logic            valid_o;
  logic            stall_i    = 1'b0;
  out_t            data_o;
  logic            cfg_we_i   = 1'b0;
  logic [EN_W-1:0] cfg_data_i = '0;

  in_t         pending_samples[$];
  out_t        expected_results[$];
  int unsigned error_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // bench copy of the filter state
  logic [SAMPLE_W-1:0] ring [CHANNELS][WINDOW];
  logic [SUM_W-1:0]    window_sum [CHANNELS];
  logic [AVG_BITS-1:0] slot [CHANNELS];
  logic [EN_W-1:0]     enable_mask = EN_RESET;

  multichannel_moving_average #(
    .AVG_BITS(AVG_BITS),
    .CHANNELS(CHANNELS)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (valid_i),
    .stall_o   (stall_o),
    .data_i    (data_i),
    .valid_o   (valid_o),
    .stall_i   (stall_i),
    .data_o    (data_o),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic in_t sample_item(input int unsigned ch, input int unsigned v);
    in_t s;
    s.channel = CH_FIELD_W'(ch);
    s.sample  = SAMPLE_W'(v);
    return s;
  endfunction

  function automatic void track_sample(input in_t s);
    int unsigned         ch;
    logic [SAMPLE_W-1:0] mean;
    out_t                r;
    ch = 32'(s.channel);
    if (!enable_mask[ch] || ch >= CHANNELS) return;
    window_sum[ch]     = window_sum[ch] - SUM_W'(ring[ch][slot[ch]]) + SUM_W'(s.sample);
    ring[ch][slot[ch]] = s.sample;
    slot[ch]           = slot[ch] + AVG_BITS'(1);
    mean = SAMPLE_W'(window_sum[ch] >> AVG_BITS);
    r.out_channel = s.channel;
    r.average     = mean;
    r.millivolts  = SAMPLE_W'((32'(mean) * 32'(FULL_SCALE_MV)) / 32'(FULL_SCALE_CD));
    expected_results.push_back(r);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_i <= 1'b0;
      data_i  <= '0;
    end else if (!valid_i || !stall_o) begin
      if (valid_i) track_sample(data_i);
      if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        valid_i <= 1'b1;
        data_i  <= pending_samples.pop_front();
      end else begin
        valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    out_t want;
    if (!rst_ni) begin
      stall_i <= 1'b0;
    end else begin
      if (valid_o && !stall_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: out_channel %0d average %0d millivolts %0d",
                 data_o.out_channel, data_o.average, data_o.millivolts);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (data_o.out_channel !== want.out_channel) begin
            $error("out_channel mismatch: expected %0d, got %0d",
                   want.out_channel, data_o.out_channel);
            error_count++;
          end
          if (data_o.average !== want.average) begin
            $error("average mismatch: expected %0d, got %0d",
                   want.average, data_o.average);
            error_count++;
          end
          if (data_o.millivolts !== want.millivolts) begin
            $error("millivolts mismatch: expected %0d, got %0d",
                   want.millivolts, data_o.millivolts);
            error_count++;
          end
        end
      end
      stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic wait_drained();
    while (pending_samples.size() != 0 || valid_i || expected_results.size() != 0)
      @(negedge clk_i);
    // dropped samples leave no expectation behind
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_enable_mask(input logic [EN_W-1:0] mask);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= mask;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    enable_mask = mask;
  endtask

  task automatic queue_random_samples(input int unsigned n_passed);
    int unsigned         passed;
    int unsigned         ch;
    logic [SAMPLE_W-1:0] v;
    passed = 0;
    while (passed < n_passed) begin
      ch = $urandom_range(CHANNELS - 1);
      // mostly enabled channels, some dropped ones as noise
      if (!enable_mask[ch] && $urandom_range(4) != 0) continue;
      case ($urandom_range(9))
        0:       v = '0;
        1:       v = '1;
        2:       v = SAMPLE_W'($urandom_range(15));
        3:       v = SAMPLE_W'(4095 - $urandom_range(15));
        default: v = SAMPLE_W'($urandom);
      endcase
      if ($urandom_range(19) == 0) begin
        // fill the whole window with one level
        repeat (WINDOW) pending_samples.push_back(sample_item(ch, v));
        if (enable_mask[ch]) passed += WINDOW;
      end else begin
        pending_samples.push_back(sample_item(ch, v));
        if (enable_mask[ch]) passed++;
      end
    end
  endtask

  initial begin
    logic [EN_W-1:0] mask;
    for (int c = 0; c < CHANNELS; c++) begin
      window_sum[c] = '0;
      slot[c]       = '0;
      for (int w = 0; w < WINDOW; w++) ring[c][w] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_enable_mask(EN_RESET);
    // ramp of a fresh window to full scale, then eviction
    repeat (WINDOW) pending_samples.push_back(sample_item(0, 4095));
    pending_samples.push_back(sample_item(1, 0));
    pending_samples.push_back(sample_item(2, 12'hAAA));
    pending_samples.push_back(sample_item(2, 12'h555));
    pending_samples.push_back(sample_item(3, 4095));
    pending_samples.push_back(sample_item(1, 4095));
    pending_samples.push_back(sample_item(0, 0));
    pending_samples.push_back(sample_item(3, 1));
    wait_drained();

    // all channels disabled: every transaction dropped
    write_enable_mask('0);
    for (int c = 0; c < CHANNELS; c++) pending_samples.push_back(sample_item(c, 4095));
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct  = SEND_IDLE[p % 4];
      recv_stall_pct = RECV_STALL[p % 4];
      mask = PHASE_MASK[p];
      if (mask == '0) mask = EN_W'($urandom_range(15, 1));
      write_enable_mask(mask);
      queue_random_samples(PER_PHASE);
      wait_drained();
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $error("timeout: %0d results outstanding", expected_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/mma_pkg.sv
rtl/core/multichannel_moving_average.sv
rtl/core/mma_checker.sv
dv/tb_top.sv
